[hdl/bsfe_pkg.sv]
// Shared types and constants of the byte stuffing frame encoder.
package bsfe_pkg;

  // Second byte of an escape pair for a stuffed flag and a stuffed escape byte.
  localparam logic [7:0] STUFF_FLAG_CODE = 8'h5E;
  localparam logic [7:0] STUFF_ESC_CODE  = 8'h5D;

  // Register file layout: register index as seen at paddr[4:2].
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FLAG    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ADDRESS = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CTRL0   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CTRL1   = 3'd4;
  localparam int unsigned PADDR_W = 5;

  // Reset values of the registers.
  localparam logic [7:0] RST_FLAG    = 8'h7E;
  localparam logic [7:0] RST_ESCAPE  = 8'h7D;
  localparam logic [7:0] RST_ADDRESS = 8'h01;
  localparam logic [7:0] RST_CTRL0   = 8'h00;
  localparam logic [7:0] RST_CTRL1   = 8'h40;

  // Depth of the queue between front and back; must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // Current register contents.
  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] address;
    logic [7:0] ctrl0;
    logic [7:0] ctrl1;
  } bsfe_cfg_t;

  // One classified payload byte as handed from front to back.
  typedef struct packed {
    logic [7:0] data;       // raw payload byte
    logic       stuffed;    // byte goes out as an escape pair
    logic [7:0] code;       // second byte of the escape pair
    logic       frame_start;
    logic       frame_end;
    logic [7:0] ctrl;       // control byte of the header
    logic [7:0] check;      // check byte sent when the frame ends here
  } bsfe_entry_t;

endpackage

[hdl/bsfe_front.sv]
// Front end: accepts payload beats, classifies them and keeps the running check byte.
module bsfe_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bsfe_pkg::bsfe_cfg_t   cfg_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] payload_byte
  input  logic                  s_axis_tlast,   // frame_end
  input  logic [1:0]            s_axis_tuser,   // [0] frame_start, [1] sequence_bit
  input  logic                  full_i,
  output logic                  push_o,
  output bsfe_pkg::bsfe_entry_t entry_o
);
  import bsfe_pkg::*;

  logic [7:0] acc_q, acc_d;
  logic [7:0] acc_base;
  logic [7:0] acc_new;
  logic       is_flag;
  logic       is_esc;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  // Classify the byte; the flag test wins when flag and escape are equal.
  always_comb begin
    is_flag  = (s_axis_tdata == cfg_i.flag);
    is_esc   = (s_axis_tdata == cfg_i.escape);
    acc_base = s_axis_tuser[0] ? 8'h00 : acc_q;
    entry_o.data        = s_axis_tdata;
    entry_o.stuffed     = is_flag || is_esc;
    entry_o.code        = is_flag ? STUFF_FLAG_CODE : STUFF_ESC_CODE;
    entry_o.frame_start = s_axis_tuser[0];
    entry_o.frame_end   = s_axis_tlast;
    entry_o.ctrl        = s_axis_tuser[1] ? cfg_i.ctrl1 : cfg_i.ctrl0;
    if (entry_o.stuffed) begin
      acc_new = acc_base ^ cfg_i.escape ^ entry_o.code;
    end else begin
      acc_new = acc_base ^ s_axis_tdata;
    end
    entry_o.check = acc_new;
  end

  // Running check byte; cleared once a frame end has passed.
  always_comb begin
    acc_d = acc_q;
    if (push_o) begin
      acc_d = s_axis_tlast ? 8'h00 : acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 8'h00;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

[hdl/bsfe_queue.sv]
// Short queue of classified beats between front and back.
module bsfe_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bsfe_pkg::bsfe_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output bsfe_pkg::bsfe_entry_t head_o
);
  import bsfe_pkg::*;

  bsfe_entry_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count; pointers wrap naturally at the power-of-two depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue written while full");
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue fill count out of range");
`endif

endmodule

[hdl/bsfe_back.sv]
// Back end: steps through the line bytes of each queued beat into the output register.
module bsfe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bsfe_pkg::bsfe_cfg_t   cfg_i,
  input  logic                  head_valid_i,
  input  bsfe_pkg::bsfe_entry_t head_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] line_byte
  output logic                  m_axis_tlast,   // run_last
  output logic                  m_axis_tuser    // frame_complete
);
  import bsfe_pkg::*;

  typedef enum logic [3:0] {
    ST_BEGIN,
    ST_FLAG,
    ST_ADDR,
    ST_CTRL,
    ST_HCHK,
    ST_DATA0,
    ST_DATA1,
    ST_CHECK,
    ST_CLOSE
  } step_e;

  step_e      step_q;
  step_e      cur;
  step_e      nxt;
  logic       done;
  logic       load;
  logic [7:0] byte_val;
  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       close_q;

  // The output register takes a byte when it is empty or being drained.
  assign load  = head_valid_i && (!valid_q || m_axis_tready);
  assign pop_o = load && done;

  // Current step, its byte and the step after it.
  always_comb begin
    cur = step_q;
    if (step_q == ST_BEGIN) begin
      cur = head_i.frame_start ? ST_FLAG : ST_DATA0;
    end
    done     = 1'b0;
    nxt      = ST_BEGIN;
    byte_val = head_i.data;
    unique case (cur)
      ST_FLAG: begin
        byte_val = cfg_i.flag;
        nxt      = ST_ADDR;
      end
      ST_ADDR: begin
        byte_val = cfg_i.address;
        nxt      = ST_CTRL;
      end
      ST_CTRL: begin
        byte_val = head_i.ctrl;
        nxt      = ST_HCHK;
      end
      ST_HCHK: begin
        byte_val = cfg_i.address ^ head_i.ctrl;
        nxt      = ST_DATA0;
      end
      ST_DATA0: begin
        byte_val = head_i.stuffed ? cfg_i.escape : head_i.data;
        if (head_i.stuffed) begin
          nxt = ST_DATA1;
        end else if (head_i.frame_end) begin
          nxt = ST_CHECK;
        end else begin
          done = 1'b1;
        end
      end
      ST_DATA1: begin
        byte_val = head_i.code;
        if (head_i.frame_end) begin
          nxt = ST_CHECK;
        end else begin
          done = 1'b1;
        end
      end
      ST_CHECK: begin
        byte_val = head_i.check;
        nxt      = ST_CLOSE;
      end
      ST_CLOSE: begin
        byte_val = cfg_i.flag;
        done     = 1'b1;
      end
      default: begin
        byte_val = head_i.data;
        done     = 1'b1;
      end
    endcase
  end

  // Step register and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_BEGIN;
      valid_q <= 1'b0;
      data_q  <= 8'h00;
      last_q  <= 1'b0;
      close_q <= 1'b0;
    end else begin
      if (load) begin
        step_q  <= nxt;
        valid_q <= 1'b1;
        data_q  <= byte_val;
        last_q  <= done;
        close_q <= (cur == ST_CLOSE);
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = close_q;

`ifndef NO_ASSERTIONS
  a_close_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && close_q) |-> last_q) else $error("closing flag not last of run");
  a_close_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cur == ST_CLOSE) |-> head_i.frame_end) else $error("close without frame end");
  a_begin_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (step_q == ST_BEGIN)) else $error("step not rewound after pop");
`endif

endmodule

[hdl/byte_stuffing_frame_encoder_unit.sv]
// Top level of the byte stuffing frame encoder with its register file.
//
// Usage: payload bytes of an information frame enter on the s_axis channel, one
// per beat, with frame_start and sequence_bit in tuser and frame_end in tlast.
// Encoded line bytes leave on the m_axis channel, one per beat; tlast marks the
// last line byte caused by an input beat and tuser marks the closing flag.
// A beat with a start mark yields flag, address, control and address XOR control
// ahead of its payload; a flag or escape payload byte goes out as an escape pair;
// a beat with an end mark appends the check byte and a closing flag.
// An accepted beat is written into the queue and then into the output register
// before its first line byte shows. The back end emits one line byte per cycle unless
// the queue is empty or the receiver stalls; a beat yields one line byte for a plain
// byte, two for a stuffed one, four more for a header and two more for a frame end.
// A two-entry queue lets the front take new beats while the back works on earlier ones.
// The APB port holds five 8-bit registers at byte addresses 0x0 to 0x10; write
// them only while the encoder is idle. Reset restores their default values and
// clears the check byte, the queue and the output register.
// When the receiver stalls, the output byte holds, the queue fills and then
// s_axis_tready drops until space frees up.
module byte_stuffing_frame_encoder_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] payload_byte
  input  logic                         s_axis_tlast,  // frame_end
  input  logic [1:0]                   s_axis_tuser,  // [0] frame_start, [1] sequence_bit
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] line_byte
  output logic                         m_axis_tlast,  // run_last
  output logic                         m_axis_tuser,  // frame_complete
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsfe_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bsfe_pkg::*;

  bsfe_cfg_t              cfg_q;
  logic                   cfg_we;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   push;
  logic                   full;
  logic                   pop;
  logic                   head_valid;
  bsfe_entry_t            entry;
  bsfe_entry_t            head;

  // Register file: write in the access cycle, no wait states.
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag    <= RST_FLAG;
      cfg_q.escape  <= RST_ESCAPE;
      cfg_q.address <= RST_ADDRESS;
      cfg_q.ctrl0   <= RST_CTRL0;
      cfg_q.ctrl1   <= RST_CTRL1;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_FLAG:    cfg_q.flag    <= pwdata[7:0];
        REG_ESCAPE:  cfg_q.escape  <= pwdata[7:0];
        REG_ADDRESS: cfg_q.address <= pwdata[7:0];
        REG_CTRL0:   cfg_q.ctrl0   <= pwdata[7:0];
        REG_CTRL1:   cfg_q.ctrl1   <= pwdata[7:0];
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      REG_FLAG:    prdata = {24'h0, cfg_q.flag};
      REG_ESCAPE:  prdata = {24'h0, cfg_q.escape};
      REG_ADDRESS: prdata = {24'h0, cfg_q.address};
      REG_CTRL0:   prdata = {24'h0, cfg_q.ctrl0};
      REG_CTRL1:   prdata = {24'h0, cfg_q.ctrl1};
      default:     prdata = 32'h0;
    endcase
  end

  bsfe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (entry)
  );

  bsfe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  bsfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[test/byte_stuffing_frame_encoder_unit_tb.sv]
// Self-checking testbench of the byte stuffing frame encoder: random frames, stalls and register settings.
module byte_stuffing_frame_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsfe_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 131;

  // One encoded line byte as seen on the master side.
  typedef struct {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_complete;
  } line_beat_t;

  // Tracks register contents and the running check byte, and holds the line bytes still due.
  class frame_scoreboard;
    logic [7:0]  flag_reg;
    logic [7:0]  escape_reg;
    logic [7:0]  address_reg;
    logic [7:0]  ctrl0_reg;
    logic [7:0]  ctrl1_reg;
    logic [7:0]  check_acc;
    line_beat_t  cur_run[$];
    line_beat_t  due_lines[$];
    int unsigned fail_count;

    function new();
      flag_reg    = RST_FLAG;
      escape_reg  = RST_ESCAPE;
      address_reg = RST_ADDRESS;
      ctrl0_reg   = RST_CTRL0;
      ctrl1_reg   = RST_CTRL1;
      check_acc   = 8'h00;
      fail_count  = 0;
    endfunction

    // Writes to unused indexes leave every register untouched.
    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [7:0] value);
      case (idx)
        REG_FLAG:    flag_reg    = value;
        REG_ESCAPE:  escape_reg  = value;
        REG_ADDRESS: address_reg = value;
        REG_CTRL0:   ctrl0_reg   = value;
        REG_CTRL1:   ctrl1_reg   = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] read_reg(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_FLAG:    return flag_reg;
        REG_ESCAPE:  return escape_reg;
        REG_ADDRESS: return address_reg;
        REG_CTRL0:   return ctrl0_reg;
        REG_CTRL1:   return ctrl1_reg;
        default:     return 8'h00;
      endcase
    endfunction

    function void flag_error(string msg);
      if (fail_count < 10) begin
        $display("mismatch: %s", msg);
      end
      fail_count++;
    endfunction

    function void queue_line(logic [7:0] value, logic closing);
      line_beat_t beat;
      beat.line_byte      = value;
      beat.run_last       = 1'b0;
      beat.frame_complete = closing;
      cur_run.push_back(beat);
    endfunction

    // Works out the line bytes caused by one accepted payload beat.
    function void note_payload(logic [7:0] payload, logic start_mark, logic end_mark,
                               logic seq_bit);
      logic [7:0] ctl;
      logic [7:0] code;
      cur_run.delete();
      // A start mark sends the header and restarts the check byte.
      if (start_mark) begin
        ctl = seq_bit ? ctrl1_reg : ctrl0_reg;
        queue_line(flag_reg, 1'b0);
        queue_line(address_reg, 1'b0);
        queue_line(ctl, 1'b0);
        queue_line(address_reg ^ ctl, 1'b0);
        check_acc = 8'h00;
      end
      // The flag test wins over the escape test when both registers match.
      if (payload == flag_reg || payload == escape_reg) begin
        code = (payload == flag_reg) ? STUFF_FLAG_CODE : STUFF_ESC_CODE;
        queue_line(escape_reg, 1'b0);
        queue_line(code, 1'b0);
        check_acc = check_acc ^ escape_reg ^ code;
      end else begin
        queue_line(payload, 1'b0);
        check_acc = check_acc ^ payload;
      end
      // An end mark appends the unstuffed check byte and the closing flag.
      if (end_mark) begin
        queue_line(check_acc, 1'b0);
        queue_line(flag_reg, 1'b1);
        check_acc = 8'h00;
      end
      cur_run[cur_run.size()-1].run_last = 1'b1;
      foreach (cur_run[i]) due_lines.push_back(cur_run[i]);
    endfunction

    // Compares one accepted line byte with the oldest one still due.
    function void check_line(logic [7:0] line_byte, logic run_last, logic frame_complete);
      line_beat_t due;
      if (due_lines.size() == 0) begin
        flag_error($sformatf("unexpected line byte %02h last %b complete %b",
                             line_byte, run_last, frame_complete));
        return;
      end
      due = due_lines.pop_front();
      if (line_byte !== due.line_byte || run_last !== due.run_last ||
          frame_complete !== due.frame_complete) begin
        flag_error($sformatf("line byte exp %02h/%b/%b got %02h/%b/%b",
                             due.line_byte, due.run_last, due.frame_complete,
                             line_byte, run_last, frame_complete));
      end
    endfunction

    function int unsigned pending();
      return due_lines.size();
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = 8'h00;  // [7:0] payload_byte
  logic                 s_axis_tlast  = 1'b0;   // frame_end
  logic [1:0]           s_axis_tuser  = 2'b00;  // [0] frame_start, [1] sequence_bit
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;           // [7:0] line_byte
  logic                 m_axis_tlast;           // run_last
  logic                 m_axis_tuser;           // frame_complete
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PADDR_W-1:0]   paddr         = '0;
  logic [31:0]          pwdata        = 32'h0;
  logic [31:0]          prdata;
  logic                 pready;

  frame_scoreboard sb = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  bit              hold_req      = 1'b0;
  int unsigned     hold_left     = 0;
  int unsigned     cycle_count   = 0;

  byte_stuffing_frame_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run time guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: checks every accepted beat, then stalls at random or for a long hold-off.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        sb.check_line(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one payload beat, with random gaps ahead of it, and waits until it is taken.
  task automatic push_payload(logic [7:0] payload, logic start_mark, logic end_mark,
                              logic seq_bit);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= payload;
    s_axis_tlast  <= end_mark;
    s_axis_tuser  <= {seq_bit, start_mark};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_payload(payload, start_mark, end_mark, seq_bit);
  endtask

  // Stops sending and waits until every due line byte has arrived.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic apb_read(logic [REG_IDX_W-1:0] idx, output logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value   = prdata[7:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(logic [7:0] flag_v, logic [7:0] escape_v, logic [7:0] addr_v,
                              logic [7:0] ctrl0_v, logic [7:0] ctrl1_v);
    apb_write(REG_FLAG, flag_v);
    apb_write(REG_ESCAPE, escape_v);
    apb_write(REG_ADDRESS, addr_v);
    apb_write(REG_CTRL0, ctrl0_v);
    apb_write(REG_CTRL1, ctrl1_v);
  endtask

  // Reads back all five registers against the tracked copy.
  task automatic verify_regs();
    logic [7:0] value;
    for (int i = REG_FLAG; i <= REG_CTRL1; i++) begin
      apb_read(REG_IDX_W'(i), value);
      if (value !== sb.read_reg(REG_IDX_W'(i))) begin
        sb.flag_error($sformatf("register %0d exp %02h got %02h", i,
                                sb.read_reg(REG_IDX_W'(i)), value));
      end
    end
  endtask

  // Payload bytes lean toward the flag and escape values so stuffing is frequent.
  function automatic logic [7:0] pick_payload();
    case ($urandom_range(7))
      0:       return sb.flag_reg;
      1:       return sb.escape_reg;
      default: return 8'($urandom());
    endcase
  endfunction

  // Mostly well-formed frames; some lack a start or end mark, some beats carry random marks.
  task automatic random_frames(int unsigned count);
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    logic        seq_bit;
    logic        with_start;
    logic        with_end;
    sent = 0;
    while (sent < count) begin
      kind    = $urandom_range(19);
      seq_bit = 1'($urandom_range(1));
      if (kind == 0) begin
        push_payload(pick_payload(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     seq_bit);
        sent++;
      end else begin
        len        = ($urandom_range(9) == 0) ? $urandom_range(20, 8) : $urandom_range(5, 1);
        with_start = (kind != 1);
        with_end   = (kind != 2);
        for (int i = 0; i < len; i++) begin
          push_payload(pick_payload(), with_start && (i == 0), with_end && (i == len - 1),
                       seq_bit);
        end
        sent += len;
      end
    end
  endtask

  // Main sequence.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles a little, receiver a lot.
    send_idle_pct = 17;
    recv_idle_pct = 71;

    // One-byte frames with both sequence values and the byte extremes.
    push_payload(8'h00, 1'b1, 1'b1, 1'b0);
    push_payload(8'hFF, 1'b1, 1'b1, 1'b1);
    // Flag, escape and the two code values inside one frame.
    push_payload(RST_FLAG, 1'b1, 1'b0, 1'b1);
    push_payload(RST_ESCAPE, 1'b0, 1'b0, 1'b1);
    push_payload(STUFF_FLAG_CODE, 1'b0, 1'b0, 1'b1);
    push_payload(STUFF_ESC_CODE, 1'b0, 1'b1, 1'b1);
    // No start mark after a finished frame: the check starts from zero, no header.
    push_payload(8'h11, 1'b0, 1'b0, 1'b0);
    push_payload(8'h22, 1'b0, 1'b1, 1'b0);
    // A new start mark in the middle of an open frame restarts the check byte.
    push_payload(8'h33, 1'b1, 1'b0, 1'b0);
    push_payload(8'h44, 1'b0, 1'b0, 1'b0);
    push_payload(8'h55, 1'b1, 1'b1, 1'b1);
    // One-byte frames whose only byte needs stuffing, with an unmarked byte between them.
    push_payload(RST_FLAG, 1'b1, 1'b1, 1'b0);
    push_payload(8'hA5, 1'b0, 1'b0, 1'b0);
    push_payload(RST_ESCAPE, 1'b1, 1'b1, 1'b1);
    wait_drained();

    // Flag and escape set equal: the flag code is used.
    apb_write(REG_FLAG, 8'h42);
    apb_write(REG_ESCAPE, 8'h42);
    push_payload(8'h42, 1'b1, 1'b0, 1'b0);
    push_payload(8'h43, 1'b0, 1'b0, 1'b0);
    push_payload(8'h42, 1'b0, 1'b1, 1'b0);
    wait_drained();

    // First random phase with one extreme setting.
    program_regs(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
    verify_regs();
    random_frames(PHASE_ITEMS);
    wait_drained();

    // Second phase: roles of the idle rates swapped, the other extreme, unused indexes.
    send_idle_pct = 71;
    recv_idle_pct = 17;
    program_regs(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
    for (int i = REG_CTRL1 + 1; i < 2 ** REG_IDX_W; i++) begin
      apb_write(REG_IDX_W'(i), 8'($urandom()));
    end
    verify_regs();
    random_frames(PHASE_ITEMS);
    wait_drained();

    // Third phase: no idling, random setting, and a long receiver hold-off up front.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                 8'($urandom()));
    verify_regs();
    hold_req = 1'b1;
    random_frames(PHASE_ITEMS);
    wait_drained();

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
